// ===== rtl/core/mas_pkg.sv =====
package mas_pkg;

	localparam int DIM_W = 4;
	localparam int IDX_W = 3;
	localparam int VALUE_W = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

	typedef struct packed {
		logic mul;
		logic sub;
		logic [DIM_W-1:0] ra;
		logic [DIM_W-1:0] ni;
		logic [DIM_W-1:0] cb;
	} job_t;

	typedef struct packed {
		logic mul;
		logic sub;
		logic first;
		logic lastk;
		logic last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} tag_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
			input logic [DIM_W-1:0] mx);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0) begin
			r = 4'd1;
		end else if (d > mx) begin
			r = mx;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/matrix_add_sub_multiply_core.sv =====
// Integer matrix add, subtract and multiply engine.
// Configure operation, rows_a, inner_size and cols_b through the write port
// while the block is idle, then send matrix A followed by matrix B on the
// input channel, one signed element per item, each in row-major order.
// Loading takes one item per cycle. Once the last element of B is taken, the
// result matrix leaves on the output channel in row-major order with row,
// column and last tags. Add and subtract deliver one result per cycle while
// the output does not stall. Multiply runs one multiply-accumulate per cycle
// on a single multiplier while the output does not stall, summing inner_size
// products per result. Per problem the input takes rows_a*inner_size elements
// of A plus the elements of B, then stays not ready while the compute runs,
// longer while the output stalls.
// The input is not ready while a result matrix is being computed, since the
// compute side reads the element stores through their single read ports.
// A stall on the output freezes the compute pipeline in place; nothing drops.
// Reset clears the registers to add with 1x1 sizes and the load counters;
// the element stores hold no defined value until loaded.
module matrix_add_sub_multiply_core #(
	parameter int MAX_DIM = 8,
	parameter int ELEMENT_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [mas_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [mas_pkg::DIM_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [ELEMENT_BITS-1:0] element,
	output logic out_valid,
	input logic out_ready,
	output logic [mas_pkg::VALUE_W-1:0] value,
	output logic [mas_pkg::IDX_W-1:0] row,
	output logic [mas_pkg::IDX_W-1:0] column,
	output logic last
);
	import mas_pkg::*;

	localparam int IW = $clog2(MAX_DIM * MAX_DIM);

	logic wr_en, wr_sel_b, push, pop, busy, fifo_nempty;
	logic [IW-1:0] wr_addr;
	logic [ELEMENT_BITS-1:0] wr_data;
	job_t push_job, head;

	mas_front #(.MAX_DIM(MAX_DIM), .ELEMENT_BITS(ELEMENT_BITS)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.element(element),
		.back_busy(busy),
		.fifo_nempty(fifo_nempty),
		.wr_en(wr_en),
		.wr_sel_b(wr_sel_b),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.push(push),
		.push_job(push_job)
	);

	mas_job_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.nempty(fifo_nempty),
		.head(head)
	);

	mas_back #(.MAX_DIM(MAX_DIM), .ELEMENT_BITS(ELEMENT_BITS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_sel_b(wr_sel_b),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.fifo_nempty(fifo_nempty),
		.head(head),
		.pop(pop),
		.busy(busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value(value),
		.row(row),
		.column(column),
		.last(last)
	);

endmodule

// ===== rtl/core/mas_front.sv =====
module mas_front #(
	parameter int MAX_DIM = 8,
	parameter int ELEMENT_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_write,
	input logic [mas_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [mas_pkg::DIM_W-1:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic [ELEMENT_BITS-1:0] element,
	input logic back_busy,
	input logic fifo_nempty,
	output logic wr_en,
	output logic wr_sel_b,
	output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
	output logic [ELEMENT_BITS-1:0] wr_data,
	output logic push,
	output mas_pkg::job_t push_job
);
	import mas_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [1:0] op_q;
	logic [DIM_W-1:0] rows_q, inner_q, cols_q;
	logic [DIM_W-1:0] ra, ni, cb;
	logic [CW-1:0] cnt_q;
	logic loading_b_q;
	logic accept, mul;
	logic [7:0] size_a, size_b, cnt_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_ADD;
			rows_q <= 4'd1;
			inner_q <= 4'd1;
			cols_q <= 4'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_OPERATION: op_q <= cfg_data[1:0];
				REG_ROWS_A: rows_q <= cfg_data;
				REG_INNER_SIZE: inner_q <= cfg_data;
				REG_COLS_B: cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign ra = clamp_dim(rows_q, DIM_W'(MAX_DIM));
	assign ni = clamp_dim(inner_q, DIM_W'(MAX_DIM));
	assign cb = clamp_dim(cols_q, DIM_W'(MAX_DIM));
	assign mul = op_q[1];
	assign size_a = 8'(ra) * 8'(ni);
	assign size_b = mul ? 8'(ni) * 8'(cb) : size_a;
	assign cnt_nx = 8'(cnt_q) + 8'd1;

	// hold off new items until the back end has finished reading the stores
	assign in_ready = !fifo_nempty && !back_busy;
	assign accept = in_valid && in_ready;

	assign wr_en = accept;
	assign wr_sel_b = loading_b_q;
	assign wr_addr = cnt_q[IW-1:0];
	assign wr_data = element;

	assign push = accept && loading_b_q && (cnt_nx >= size_b);
	assign push_job = '{mul: mul, sub: (op_q == OP_SUB), ra: ra, ni: ni, cb: cb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			loading_b_q <= 1'b0;
		end else if (accept) begin
			if (!loading_b_q) begin
				if (cnt_nx >= size_a) begin
					cnt_q <= '0;
					loading_b_q <= 1'b1;
				end else begin
					cnt_q <= CW'(cnt_nx);
				end
			end else begin
				if (cnt_nx >= size_b) begin
					cnt_q <= '0;
					loading_b_q <= 1'b0;
				end else begin
					cnt_q <= CW'(cnt_nx);
				end
			end
		end
	end

endmodule

// ===== rtl/core/mas_job_fifo.sv =====
module mas_job_fifo (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mas_pkg::job_t push_job,
	input logic pop,
	output logic nempty,
	output mas_pkg::job_t head
);
	import mas_pkg::*;

	job_t slot_q [2];
	logic wp_q, rp_q;
	logic [1:0] fill_q;
	logic do_push, do_pop;

	assign nempty = (fill_q != 2'd0);
	assign head = slot_q[rp_q];
	assign do_pop = pop && nempty;
	assign do_push = push && (fill_q != 2'd2);

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wp_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (do_push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			case ({do_push, do_pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/mas_back.sv =====
module mas_back #(
	parameter int MAX_DIM = 8,
	parameter int ELEMENT_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic wr_sel_b,
	input logic [$clog2(MAX_DIM*MAX_DIM)-1:0] wr_addr,
	input logic [ELEMENT_BITS-1:0] wr_data,
	input logic fifo_nempty,
	input mas_pkg::job_t head,
	output logic pop,
	output logic busy,
	output logic out_valid,
	input logic out_ready,
	output logic [mas_pkg::VALUE_W-1:0] value,
	output logic [mas_pkg::IDX_W-1:0] row,
	output logic [mas_pkg::IDX_W-1:0] column,
	output logic last
);
	import mas_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int IW = $clog2(DEPTH);
	localparam int PW = 2 * ELEMENT_BITS;
	localparam int XW = (PW > VALUE_W) ? PW : VALUE_W;

	logic [ELEMENT_BITS-1:0] mem_a [DEPTH];
	logic [ELEMENT_BITS-1:0] mem_b [DEPTH];

	job_t job_q;
	logic active_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic [IW-1:0] abase_q, bk_q;
	logic [IW-1:0] a_addr, b_addr;
	logic [DIM_W-1:0] kcnt, ncols;
	logic lastk, lastj, lasti, adv;

	logic v_s1, v_s2;
	tag_t tag_s1, tag_s2;
	logic signed [ELEMENT_BITS-1:0] a_s1, b_s1;
	logic [VALUE_W-1:0] res_s2, acc_q, res_nx, sum_nx;
	logic signed [PW-1:0] prod;
	logic signed [ELEMENT_BITS:0] addsub;
	logic signed [XW-1:0] prod_x, addsub_x;

	logic out_valid_q, last_q;
	logic [VALUE_W-1:0] value_q;
	logic [IDX_W-1:0] row_q, col_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			if (wr_sel_b) begin
				mem_b[wr_addr] <= wr_data;
			end else begin
				mem_a[wr_addr] <= wr_data;
			end
		end
	end

	// whole pipeline freezes while a result waits at the output
	assign adv = !out_valid_q || out_ready;
	assign busy = active_q;
	assign pop = !active_q && fifo_nempty;

	assign kcnt = job_q.mul ? job_q.ni : 4'd1;
	assign ncols = job_q.mul ? job_q.cb : job_q.ni;
	assign lastk = ({1'b0, k_q} == kcnt - 4'd1);
	assign lastj = ({1'b0, j_q} == ncols - 4'd1);
	assign lasti = ({1'b0, i_q} == job_q.ra - 4'd1);
	assign a_addr = abase_q + (job_q.mul ? IW'(k_q) : IW'(j_q));
	assign b_addr = (job_q.mul ? bk_q : abase_q) + IW'(j_q);

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			abase_q <= '0;
			bk_q <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			abase_q <= '0;
			bk_q <= '0;
		end else if (active_q && adv) begin
			if (!lastk) begin
				k_q <= k_q + 3'd1;
				bk_q <= bk_q + IW'(job_q.cb);
			end else begin
				k_q <= '0;
				bk_q <= '0;
				if (!lastj) begin
					j_q <= j_q + 3'd1;
				end else begin
					j_q <= '0;
					if (!lasti) begin
						i_q <= i_q + 3'd1;
						abase_q <= abase_q + IW'(job_q.ni);
					end else begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

	// stage 1: store read
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s1 <= mem_a[a_addr];
			b_s1 <= mem_b[b_addr];
			tag_s1 <= '{mul: job_q.mul, sub: job_q.sub, first: (k_q == '0), lastk: lastk,
				last: lasti && lastj, row: i_q, col: j_q};
		end
	end

	// stage 2: product or elementwise sum
	assign prod = a_s1 * b_s1;
	assign prod_x = XW'(prod);
	assign addsub = tag_s1.sub ? (ELEMENT_BITS+1)'(a_s1) - (ELEMENT_BITS+1)'(b_s1)
		: (ELEMENT_BITS+1)'(a_s1) + (ELEMENT_BITS+1)'(b_s1);
	assign addsub_x = XW'(addsub);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= tag_s1.mul ? prod_x[VALUE_W-1:0] : addsub_x[VALUE_W-1:0];
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= active_q;
			v_s2 <= v_s1;
		end
	end

	// stage 3: accumulate over the inner dimension
	assign sum_nx = acc_q + res_s2;
	assign res_nx = tag_s2.first ? res_s2 : sum_nx;

	always_ff @(posedge clk) begin
		if (adv && v_s2) begin
			acc_q <= res_nx;
		end
		if (adv && v_s2 && tag_s2.lastk) begin
			value_q <= res_nx;
			row_q <= tag_s2.row;
			col_q <= tag_s2.col;
			last_q <= tag_s2.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_s2 && tag_s2.lastk;
		end
	end

	assign out_valid = out_valid_q;
	assign value = value_q;
	assign row = row_q;
	assign column = col_q;
	assign last = last_q;

endmodule
